/* sv/sha256_byte_stream_hasher_assert.svh */
// assertion macros for the hasher
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// consequent checked in the same cycle
`define SBSH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbsh assertion failed");

// consequent checked in the cycle after the antecedent
`define SBSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbsh assertion failed");

`endif

/* sv/sbsh_pkg.sv */
package sbsh_pkg;

    typedef logic [31:0] word_t;
    typedef logic [0:15][31:0] sched_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam word_t H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* sv/sbsh_if.sv */
interface sbsh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output has_byte, output is_last,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input is_last,
                  output ready);
endinterface

interface sbsh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word_a;
    logic [63:0] digest_word_b;
    logic [63:0] digest_word_c;
    logic [63:0] digest_word_d;

    modport source (output valid, output digest_word_a, output digest_word_b,
                    output digest_word_c, output digest_word_d, input ready);
    modport sink (input valid, input digest_word_a, input digest_word_b,
                  input digest_word_c, input digest_word_d, output ready);
endinterface

/* sv/sha256_byte_stream_hasher.sv */
// SHA-256 hasher for a byte stream.
// msg channel: one item per message byte (has_byte), is_last closes the message;
// a last item without a byte ends the message as is, so an empty message works.
// digest channel: one item per message, the 256-bit digest as four big-endian
// 64-bit words, digest_word_a holding digest bytes 0 to 7.
// Bytes are taken one per cycle while a block fills. The 64th byte of a block
// starts the compression: 64 rounds on the single round unit, one round per
// cycle, then a fold step adds the result into the chaining words, and msg is
// not ready during the rounds and the fold. On a last item the padding is
// shifted in one byte per cycle (0x80, zeros, bit length), then one or two
// compressions follow, two when the length spills into a second block.
// The digest sits in an output register; new bytes are taken while it waits.
// If the next message finishes while the old digest is still not taken, the
// block holds in its fold step until digest ready is seen.
// Reset (rst_n low, asynchronous) loads the initial chaining words, clears the
// byte count and drops digest valid.
module sha256_byte_stream_hasher
    import sbsh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sbsh_in_if.sink           msg,
    sbsh_out_if.source        digest
);

    typedef enum logic [3:0] {
        ST_LOAD   = 4'b0001,
        ST_ROUND  = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_PAD    = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    logic [60:0]  count_reg, count_next;
    logic [5:0]   fill_reg, fill_next;
    logic [5:0]   round_reg, round_next;
    logic         mark_reg, mark_next;
    logic         len_ok_reg, len_ok_next;
    logic         final_reg, final_next;
    logic         pend_reg, pend_next;
    logic         out_valid_reg, out_valid_next;
    word_t        chain_reg [8];
    word_t        chain_next [8];
    word_t        v_reg [8];
    word_t        v_next [8];
    sched_t       w_reg, w_next;
    logic [255:0] dig_reg, dig_next;

    logic [511:0] w_flat;
    logic         msg_fire;
    logic         out_fire;
    word_t        t1;
    word_t        t2;
    word_t        new_w;
    word_t        sums [8];
    logic [63:0]  bit_len;
    logic [7:0]   len_byte;
    logic [7:0]   pad_byte;

    assign msg.ready = (state_reg == ST_LOAD);
    assign msg_fire  = msg.valid && msg.ready;
    assign out_fire  = out_valid_reg && digest.ready;

    assign digest.valid         = out_valid_reg;
    assign digest.digest_word_a = dig_reg[255:192];
    assign digest.digest_word_b = dig_reg[191:128];
    assign digest.digest_word_c = dig_reg[127:64];
    assign digest.digest_word_d = dig_reg[63:0];

    assign w_flat   = w_reg;
    assign bit_len  = {count_reg, 3'b000};
    assign len_byte = 8'(bit_len >> {3'd7 - fill_reg[2:0], 3'b000});
    assign pad_byte = !mark_reg ? PAD_MARK
                    : (len_ok_reg && fill_reg >= LEN_START) ? len_byte : 8'h00;

    // round unit
    always_comb
    begin
        t1 = v_reg[7] + big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + K_TABLE[round_reg] + w_reg[0];
        t2 = big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        new_w = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
        for (int i = 0; i < 8; i++)
        begin
            sums[i] = chain_reg[i] + v_reg[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        mark_next      = mark_reg;
        len_ok_next    = len_ok_reg;
        final_next     = final_reg;
        pend_next      = pend_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        chain_next     = chain_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        dig_next       = dig_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (msg_fire)
                begin
                    if (msg.has_byte)
                    begin
                        w_next     = {w_flat[503:0], msg.data_byte};
                        count_next = count_reg + 61'd1;
                        fill_next  = fill_reg + 6'd1;
                        if (fill_reg == LAST_POS)
                        begin
                            state_next = ST_ROUND;
                            round_next = '0;
                            v_next     = chain_reg;
                            final_next = 1'b0;
                            pend_next  = msg.is_last;
                            mark_next  = 1'b0;
                        end
                        else if (msg.is_last)
                        begin
                            state_next = ST_PAD;
                            mark_next  = 1'b0;
                        end
                    end
                    else if (msg.is_last)
                    begin
                        state_next = ST_PAD;
                        mark_next  = 1'b0;
                    end
                end
            end
            ST_PAD:
            begin
                w_next    = {w_flat[503:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    mark_next   = 1'b1;
                    len_ok_next = (fill_reg < LEN_START);
                end
                if (fill_reg == LAST_POS)
                begin
                    state_next = ST_ROUND;
                    round_next = '0;
                    v_next     = chain_reg;
                    final_next = mark_reg && len_ok_reg;
                    pend_next  = 1'b1;
                end
            end
            ST_ROUND:
            begin
                v_next[7]  = v_reg[6];
                v_next[6]  = v_reg[5];
                v_next[5]  = v_reg[4];
                v_next[4]  = v_reg[3] + t1;
                v_next[3]  = v_reg[2];
                v_next[2]  = v_reg[1];
                v_next[1]  = v_reg[0];
                v_next[0]  = t1 + t2;
                w_next     = {w_flat[479:0], new_w};
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (final_reg)
                begin
                    // hold here while the previous digest is still waiting
                    if (!out_valid_reg || out_fire)
                    begin
                        dig_next = {sums[0], sums[1], sums[2], sums[3],
                                    sums[4], sums[5], sums[6], sums[7]};
                        out_valid_next = 1'b1;
                        chain_next     = H_INIT;
                        count_next     = '0;
                        fill_next      = '0;
                        final_next     = 1'b0;
                        pend_next      = 1'b0;
                        state_next     = ST_LOAD;
                    end
                end
                else
                begin
                    chain_next = sums;
                    if (pend_reg)
                    begin
                        state_next  = ST_PAD;
                        len_ok_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            mark_reg      <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= H_INIT;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            mark_reg      <= mark_next;
            len_ok_reg    <= len_ok_next;
            final_reg     <= final_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        w_reg   <= w_next;
        dig_reg <= dig_next;
    end

`include "sha256_byte_stream_hasher_assert.svh"

    `SBSH_ASSERT_NOW(a_round_starts_at_zero, clk, rst_n,
        (state_reg != ST_ROUND) ##1 (state_reg == ST_ROUND), round_reg == '0)
    `SBSH_ASSERT_NEXT(a_fold_after_last_round, clk, rst_n,
        (state_reg == ST_ROUND) && (round_reg == LAST_ROUND), state_reg == ST_UPDATE)
    `SBSH_ASSERT_NOW(a_fill_tracks_count, clk, rst_n,
        state_reg == ST_LOAD, fill_reg == count_reg[5:0])
    `SBSH_ASSERT_NOW(a_final_has_length, clk, rst_n,
        (state_reg == ST_UPDATE) && final_reg, mark_reg && len_ok_reg && pend_reg)

endmodule
